[rtl/rmp_pkg.sv]
// ============================================================================
// rmp_pkg
// Shared types, constants and tables for the Robinson map projection core.
// ============================================================================
`default_nettype none

package rmp_pkg;

    // Fixed-point formats
    localparam int TABLE_FRAC_BITS = 16;
    localparam int LON_FRAC_BITS   = 8;

    // Field and register widths
    localparam int LAT_W      = 8;
    localparam int LON_W      = 17;
    localparam int PIX_W      = 12;
    localparam int WIDTH_W    = 10;
    localparam int MARGIN_W   = 6;
    localparam int SHIFT_W    = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    // Pipeline depth
    localparam int STAGES = 6;

    // Band selection
    localparam int BAND_COUNT = 19;
    localparam int MAX_LAT    = 90;
    localparam int MAG_W      = 7;
    localparam int BAND_W     = 5;
    localparam int FRAC_W     = 3;
    localparam int DIV5_W     = 15;
    localparam int DIV5_SH    = 10;
    localparam int DIV5_MAGIC = 205;

    // Interpolation widths
    localparam int DEC_W = 14;
    localparam int Q_W   = TABLE_FRAC_BITS + 1;
    localparam int T5_W  = Q_W + 3;
    localparam int B_W   = Q_W + 4;
    localparam logic [B_W-1:0] FIVE_ONE = B_W'(64'd5 << TABLE_FRAC_BITS);

    // Horizontal path
    localparam int LONS_W = ((LON_W > SHIFT_W + LON_FRAC_BITS) ? LON_W
                            : SHIFT_W + LON_FRAC_BITS) + 1;
    localparam int P_W    = LONS_W + T5_W + 1;
    localparam int A_W    = P_W + 1;
    localparam int WA_W   = A_W + WIDTH_W + 1;
    localparam int XSH    = TABLE_FRAC_BITS + LON_FRAC_BITS;
    localparam logic signed [A_W-1:0] X_BIAS = A_W'(64'd900 << XSH);
    localparam int V_W       = 24;
    localparam int X_K_LOG   = 12;
    localparam int X_K       = 1 << X_K_LOG;
    localparam int X_OFFSET  = 1800 * X_K;
    localparam int U_W       = 24;
    localparam int U3_W      = U_W - 3;
    localparam int X_DIV_SH  = U3_W + 8;
    localparam int X_MAGIC_W = 22;
    localparam logic [X_MAGIC_W-1:0] X_MAGIC =
        X_MAGIC_W'(((64'd1 << X_DIV_SH) + 64'd224) / 64'd225);
    localparam int X_PROD_W  = U3_W + X_MAGIC_W;
    localparam int XQ_W      = X_PROD_W - X_DIV_SH;

    // Vertical path
    localparam int HB_W      = B_W + WIDTH_W;
    localparam int YV_W      = 13;
    localparam int Y_DIV_SH  = YV_W + 3;
    localparam int Y_MAGIC_W = 14;
    localparam logic [Y_MAGIC_W-1:0] Y_MAGIC =
        Y_MAGIC_W'(((64'd1 << Y_DIV_SH) + 64'd4) / 64'd5);
    localparam int Y_PROD_W  = YV_W + Y_MAGIC_W;
    localparam int YQ_W      = Y_PROD_W - Y_DIV_SH;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAP_WIDTH   = 3'd0,
        CFG_MAP_HEIGHT  = 3'd1,
        CFG_MARGIN_LEFT = 3'd2,
        CFG_MARGIN_TOP  = 3'd3,
        CFG_LON_SHIFT   = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic        [WIDTH_W-1:0]  draw_width;
        logic        [WIDTH_W-1:0]  draw_height;
        logic        [MARGIN_W-1:0] margin_left;
        logic        [MARGIN_W-1:0] margin_top;
        logic signed [SHIFT_W-1:0]  longitude_shift;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        draw_width:      10'd990,
        draw_height:     10'd503,
        margin_left:     6'd5,
        margin_top:      6'd2,
        longitude_shift: -9'sd10
    };

    // Four-decimal tables, index 0 at the equator
    typedef logic [BAND_COUNT-1:0][DEC_W-1:0] t_dec_tab;
    typedef logic [BAND_COUNT-1:0][Q_W-1:0]   t_q_tab;

    localparam t_dec_tab LEN_DEC = {
        14'd5322, 14'd5722, 14'd6213, 14'd6732, 14'd7186, 14'd7597, 14'd7986,
        14'd8350, 14'd8679, 14'd8962, 14'd9216, 14'd9427, 14'd9600, 14'd9730,
        14'd9822, 14'd9900, 14'd9954, 14'd9986, 14'd10000
    };

    localparam t_dec_tab DIST_DEC = {
        14'd10000, 14'd9761, 14'd9394, 14'd8936, 14'd8435, 14'd7903, 14'd7346,
        14'd6769, 14'd6176, 14'd5571, 14'd4958, 14'd4340, 14'd3720, 14'd3100,
        14'd2480, 14'd1860, 14'd1240, 14'd620, 14'd0
    };

    // Round half up to Q1.TABLE_FRAC_BITS
    function automatic t_q_tab make_q_tab(t_dec_tab dec);
        t_q_tab q;
        for (int i = 0; i < BAND_COUNT; i++) begin
            q[i] = Q_W'(((64'(dec[i]) << TABLE_FRAC_BITS) + 64'd5000) / 64'd10000);
        end
        return q;
    endfunction

    localparam t_q_tab LEN_Q  = make_q_tab(LEN_DEC);
    localparam t_q_tab DIST_Q = make_q_tab(DIST_DEC);

endpackage

`default_nettype wire

[rtl/rmp_req_if.sv]
// ============================================================================
// rmp_req_if
// Request channel: one latitude/longitude pair per handshake.
// ============================================================================
`default_nettype none

interface rmp_req_if import rmp_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [LAT_W-1:0] latitude_deg;
    logic signed [LON_W-1:0] longitude_q8;

    modport source (output valid, output latitude_deg, output longitude_q8, input ready);
    modport sink   (input valid, input latitude_deg, input longitude_q8, output ready);
endinterface

`default_nettype wire

[rtl/rmp_res_if.sv]
// ============================================================================
// rmp_res_if
// Result channel: one pixel coordinate pair per handshake.
// ============================================================================
`default_nettype none

interface rmp_res_if import rmp_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [PIX_W-1:0] pixel_x;
    logic signed [PIX_W-1:0] pixel_y;

    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

`default_nettype wire

[rtl/rmp_cfg_regs.sv]
// ============================================================================
// rmp_cfg_regs
// Configuration register file, written by index.
// ============================================================================
`default_nettype none

module rmp_cfg_regs import rmp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_MAP_WIDTH:   n_cfg.draw_width      = i_cfg_wdata[WIDTH_W-1:0];
                CFG_MAP_HEIGHT:  n_cfg.draw_height     = i_cfg_wdata[WIDTH_W-1:0];
                CFG_MARGIN_LEFT: n_cfg.margin_left     = i_cfg_wdata[MARGIN_W-1:0];
                CFG_MARGIN_TOP:  n_cfg.margin_top      = i_cfg_wdata[MARGIN_W-1:0];
                CFG_LON_SHIFT:   n_cfg.longitude_shift = i_cfg_wdata[SHIFT_W-1:0];
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

[rtl/rmp_interp.sv]
// ============================================================================
// rmp_interp
// Stages 1-2: band select, shifted longitude, table interpolation.
// ============================================================================
`default_nettype none

module rmp_interp import rmp_pkg::*; (
    input  logic                     i_clk,
    input  logic [1:0]               i_en,
    input  logic signed [LAT_W-1:0]  i_latitude_deg,
    input  logic signed [LON_W-1:0]  i_longitude_q8,
    input  t_cfg                     i_cfg,
    output logic [T5_W-1:0]          o_len5,
    output logic [B_W-1:0]           o_b,
    output logic signed [LONS_W-1:0] o_lon_s
);

    // Stage 1
    logic [LAT_W-1:0]         mag_raw;
    logic [MAG_W-1:0]         mag;
    logic [DIV5_W-1:0]        kprod;
    logic [MAG_W-1:0]         five_k;
    logic [BAND_W-1:0]        n_k;
    logic [FRAC_W-1:0]        n_f;
    logic signed [LONS_W-1:0] n_lon_s;

    logic                     r_s1_neg;
    logic [BAND_W-1:0]        r_s1_k;
    logic [FRAC_W-1:0]        r_s1_f;
    logic signed [LONS_W-1:0] r_s1_lon_s;

    always_comb begin
        mag_raw = i_latitude_deg[LAT_W-1] ? (~i_latitude_deg + 1'b1) : i_latitude_deg;
        mag     = (mag_raw > LAT_W'(MAX_LAT)) ? MAG_W'(MAX_LAT) : mag_raw[MAG_W-1:0];
        // mag / 5 by reciprocal, exact over 0..90
        kprod   = DIV5_W'(mag) * DIV5_W'(DIV5_MAGIC);
        n_k     = kprod[DIV5_SH +: BAND_W];
        five_k  = {n_k, 2'b00} + MAG_W'(n_k);
        n_f     = FRAC_W'(mag - five_k);
        n_lon_s = LONS_W'(i_longitude_q8)
                + (LONS_W'(i_cfg.longitude_shift) <<< LON_FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_s1_neg   <= i_latitude_deg[LAT_W-1];
            r_s1_k     <= n_k;
            r_s1_f     <= n_f;
            r_s1_lon_s <= n_lon_s;
        end
    end

    // Stage 2
    logic [BAND_W-1:0]      k1;
    logic signed [T5_W:0]   l0, l1, d0, d1;
    logic signed [T5_W:0]   len5_s, dist5_s;
    logic signed [FRAC_W:0] f_s;
    logic [B_W-1:0]         n_b;

    logic [T5_W-1:0]          r_s2_len5;
    logic [B_W-1:0]           r_s2_b;
    logic signed [LONS_W-1:0] r_s2_lon_s;

    always_comb begin
        // hold on the last entry at the pole
        k1      = (r_s1_k == BAND_W'(BAND_COUNT - 1)) ? r_s1_k : r_s1_k + 1'b1;
        l0      = (T5_W+1)'(LEN_Q[r_s1_k]);
        l1      = (T5_W+1)'(LEN_Q[k1]);
        d0      = (T5_W+1)'(DIST_Q[r_s1_k]);
        d1      = (T5_W+1)'(DIST_Q[k1]);
        f_s     = {1'b0, r_s1_f};
        len5_s  = (l0 <<< 2) + l0 + (l1 - l0) * f_s;
        dist5_s = (d0 <<< 2) + d0 + (d1 - d0) * f_s;
        n_b     = r_s1_neg ? FIVE_ONE + B_W'(dist5_s) : FIVE_ONE - B_W'(dist5_s);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_s2_len5  <= len5_s[T5_W-1:0];
            r_s2_b     <= n_b;
            r_s2_lon_s <= r_s1_lon_s;
        end
    end

    assign o_len5  = r_s2_len5;
    assign o_b     = r_s2_b;
    assign o_lon_s = r_s2_lon_s;

endmodule

`default_nettype wire

[rtl/rmp_project.sv]
// ============================================================================
// rmp_project
// Stages 3-6: scale by map size, floor divide by reciprocal, add margins.
// ============================================================================
`default_nettype none

module rmp_project import rmp_pkg::*; (
    input  logic                     i_clk,
    input  logic [3:0]               i_en,
    input  logic [T5_W-1:0]          i_len5,
    input  logic [B_W-1:0]           i_b,
    input  logic signed [LONS_W-1:0] i_lon_s,
    input  t_cfg                     i_cfg,
    output logic signed [PIX_W-1:0]  o_pixel_x,
    output logic signed [PIX_W-1:0]  o_pixel_y
);

    // Stage 3: longitude times parallel length, height times y term
    logic signed [P_W-1:0] n_p;
    logic [HB_W-1:0]       n_hb;
    logic signed [P_W-1:0] r_s3_p;
    logic [HB_W-1:0]       r_s3_hb;

    always_comb begin
        n_p  = P_W'(i_lon_s) * $signed({1'b0, i_len5});
        n_hb = HB_W'(i_b) * HB_W'(i_cfg.draw_height);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_s3_p  <= n_p;
            r_s3_hb <= n_hb;
        end
    end

    // Stage 4: centre offset, times width, drop the fraction (floor)
    logic signed [A_W-1:0]  n_a;
    logic signed [WA_W-1:0] n_wa;
    logic signed [V_W-1:0]  r_s4_v;
    logic [YV_W-1:0]        r_s4_yv;

    always_comb begin
        n_a  = A_W'(r_s3_p) + X_BIAS;
        n_wa = WA_W'(n_a) * $signed({1'b0, i_cfg.draw_width});
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_s4_v  <= n_wa[XSH +: V_W];
            r_s4_yv <= r_s3_hb[TABLE_FRAC_BITS + 1 +: YV_W];
        end
    end

    // Stage 5: bias x positive, reciprocal multiplies for /1800 and /5
    logic [U_W-1:0]      n_u;
    logic [X_PROD_W-1:0] r_s5_xp;
    logic [Y_PROD_W-1:0] r_s5_yp;

    always_comb begin
        n_u = U_W'(r_s4_v) + U_W'(X_OFFSET);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_s5_xp <= X_PROD_W'(n_u[U_W-1:3]) * X_PROD_W'(X_MAGIC);
            r_s5_yp <= Y_PROD_W'(r_s4_yv) * Y_PROD_W'(Y_MAGIC);
        end
    end

    // Stage 6: remove bias, add margins, wrap to pixel width
    logic [PIX_W-1:0] n_px;
    logic [PIX_W-1:0] n_py;
    logic [PIX_W-1:0] r_s6_px;
    logic [PIX_W-1:0] r_s6_py;

    always_comb begin
        n_px = PIX_W'(r_s5_xp[X_DIV_SH +: XQ_W]) - PIX_W'(X_K)
             + PIX_W'(i_cfg.margin_left);
        n_py = PIX_W'(r_s5_yp[Y_DIV_SH +: YQ_W]) + PIX_W'(i_cfg.margin_top);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_s6_px <= n_px;
            r_s6_py <= n_py;
        end
    end

    assign o_pixel_x = r_s6_px;
    assign o_pixel_y = r_s6_py;

endmodule

`default_nettype wire

[rtl/robinson_map_projection_core.sv]
// ============================================================================
// robinson_map_projection_core
// Robinson projection of latitude/longitude to signed pixel coordinates by
// table interpolation, six-stage pipeline.
// ============================================================================
//
//  Channel   Dir  Handshake        Payload
//  --------  ---  ---------------  ------------------------------------------
//  i_req     in   valid / ready    latitude_deg s8, longitude_q8 s17 (Q9.8)
//  o_res     out  valid / ready    pixel_x s12, pixel_y s12
//  i_cfg_*   in   write enable     i_cfg_idx 3b, i_cfg_wdata 10b
//
//  One request enters every cycle unless a stall on o_res has filled every
//  stage, paced by the pipeline stage registers (the widest unit is the
//  40 x 11 bit width multiplier in stage four).
//  Reset is synchronous and active low; it clears the stage valid bits and
//  loads the register defaults. Data registers are not reset.
//  A stall on o_res holds only the stages that are full: bubbles close up,
//  and i_req.ready falls only once all six stages hold a request.
//
//  Stages:
//    1  |lat| saturated to 90, band = |lat|/5 and remainder, shifted longitude
//    2  table lookup and interpolation (five times the Q1.16 value)
//    3  longitude x length, height x (5 -/+ distance)
//    4  add centre offset, times width, floor by the fraction shift
//    5  reciprocal multiply for the divisions by 1800 and by 5
//    6  remove the x bias, add margins, wrap to 12 bits
// ============================================================================
`default_nettype none

module robinson_map_projection_core import rmp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    rmp_req_if.sink               i_req,
    rmp_res_if.source             o_res
);

    t_cfg cfg;

    rmp_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // ------------------------------------------------------------------
    // Valid pipeline: a stage loads when empty or when the next one moves
    // ------------------------------------------------------------------
    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] n_vld;
    logic [STAGES:0]   stage_rdy;

    always_comb begin
        stage_rdy[STAGES] = o_res.ready;
        for (int i = STAGES - 1; i >= 0; i--) begin
            stage_rdy[i] = !r_vld[i] || stage_rdy[i+1];
        end
        n_vld[0] = stage_rdy[0] ? i_req.valid : r_vld[0];
        for (int i = 1; i < STAGES; i++) begin
            n_vld[i] = stage_rdy[i] ? r_vld[i-1] : r_vld[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign i_req.ready = stage_rdy[0];
    assign o_res.valid = r_vld[STAGES-1];

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    logic [T5_W-1:0]          len5;
    logic [B_W-1:0]           b_term;
    logic signed [LONS_W-1:0] lon_s;

    rmp_interp u_interp (
        .i_clk          (i_clk),
        .i_en           (stage_rdy[1:0]),
        .i_latitude_deg (i_req.latitude_deg),
        .i_longitude_q8 (i_req.longitude_q8),
        .i_cfg          (cfg),
        .o_len5         (len5),
        .o_b            (b_term),
        .o_lon_s        (lon_s)
    );

    rmp_project u_project (
        .i_clk     (i_clk),
        .i_en      (stage_rdy[STAGES-1:2]),
        .i_len5    (len5),
        .i_b       (b_term),
        .i_lon_s   (lon_s),
        .i_cfg     (cfg),
        .o_pixel_x (o_res.pixel_x),
        .o_pixel_y (o_res.pixel_y)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // back-pressure reaches the input only when every stage is occupied
    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req.ready |-> (&r_vld))
        else $error("request refused with a bubble in the pipeline");

    a_block_needs_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req.ready |-> !o_res.ready)
        else $error("request refused while the result side is ready");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> r_vld[0])
        else $error("accepted request missing from stage one");

    a_last_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[STAGES-2] && o_res.ready) |=> o_res.valid)
        else $error("request lost between stage five and the output");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid)
        else $error("result valid straight after reset");

endmodule

`default_nettype wire
